[rtl/rsk_pkg.sv]
// Shared types and constants of the record sorter.
`default_nettype none

package rsk_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int IDX_W       = $clog2(MAX_RECORDS);
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

	localparam int KEY_W = 32;
	localparam int PRN_W = 32;
	localparam int TAG_W = 16;

	// Sort method codes held in the mode register.
	localparam logic [1:0] METH_BUBBLE    = 2'd0;
	localparam logic [1:0] METH_SELECTION = 2'd1;
	localparam logic [1:0] METH_INSERTION = 2'd2;
	localparam logic [1:0] METH_NONE      = 2'd3;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic signed [PRN_W-1:0] prn;
		logic        [TAG_W-1:0] tag;
	} rec_t;

endpackage

`default_nettype wire

[rtl/record_sorter_by_key_core.sv]
// Record sorter: loads a set of records, sorts them by signed key in a RAM, and streams them out.
// Loading: the block takes a record whenever it is idle.
// After the last record of a set, the sort engine of the bubble, insertion or selection mode
// runs, with one RAM compare per cycle while it scans.
// Emission then reads entry zero, and gives one word per cycle while the output is not stalled.
// Reset clears the control state, the record count, the drop flag and the mode register;
// the record RAM is not cleared and only entries written in the current set are ever used.
`default_nettype none

module record_sorter_by_key_core (
	input  wire                              clk,
	input  wire                              arst_n,

	input  wire                              cfg_wr_en,
	input  wire [1:0]                        cfg_wr_data,

	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire signed [rsk_pkg::KEY_W-1:0]  record_key,
	input  wire signed [rsk_pkg::PRN_W-1:0]  record_prn,
	input  wire        [rsk_pkg::TAG_W-1:0]  record_tag,
	input  wire                              last_record,

	output logic                             out_valid,
	input  wire                              out_stall,
	output logic signed [rsk_pkg::KEY_W-1:0] sorted_key,
	output logic signed [rsk_pkg::PRN_W-1:0] sorted_prn,
	output logic        [rsk_pkg::TAG_W-1:0] sorted_tag,
	output logic                             final_result,
	output logic                             records_dropped
);
	import rsk_pkg::*;

	// Sequencer states. The bubble states serve both stable modes: bubble and insertion
	// sort give the same order for every input, since both keep equal keys in arrival order.
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DISPATCH = 4'd1;
	localparam logic [3:0] ST_B_START  = 4'd2;
	localparam logic [3:0] ST_B_FIRST  = 4'd3;
	localparam logic [3:0] ST_B_SCAN   = 4'd4;
	localparam logic [3:0] ST_B_TAIL   = 4'd5;
	localparam logic [3:0] ST_S_START  = 4'd6;
	localparam logic [3:0] ST_S_FIRST  = 4'd7;
	localparam logic [3:0] ST_S_SCAN   = 4'd8;
	localparam logic [3:0] ST_S_SW1    = 4'd9;
	localparam logic [3:0] ST_S_SW2    = 4'd10;
	localparam logic [3:0] ST_E_START  = 4'd11;
	localparam logic [3:0] ST_E_LOAD   = 4'd12;

	// Record RAM: one write port, one read port with a registered read.
	rec_t             rec_mem [MAX_RECORDS];
	rec_t             rd_data_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	rec_t             wr_data;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	logic [1:0]       method_q;

	// idx_q walks the RAM in every scan; outer_q is the end of the current bubble pass,
	// or the head position of the current selection pass.
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] outer_q;
	logic [IDX_W-1:0] best_idx_q;
	rec_t             carry_q;   // bubbled record, or the best record of a selection pass
	rec_t             head_q;    // record at the head of a selection pass

	logic             out_valid_q;
	rec_t             out_rec_q;
	logic             out_final_q;
	logic             out_drop_q;

	logic             in_accept;
	logic             full;
	logic [CNT_W-1:0] cnt_m1;
	logic [IDX_W-1:0] last_idx;
	logic             carry_gt;
	logic             out_free;
	logic             out_load;
	logic             out_last;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && (state_q == ST_IDLE);
	assign full      = (count_q == CNT_W'(MAX_RECORDS));
	assign cnt_m1    = count_q - CNT_W'(1);
	assign last_idx  = cnt_m1[IDX_W-1:0];

	// Strict signed compare: the held record has a larger key than the word just read.
	assign carry_gt  = ($signed(carry_q.key) > $signed(rd_data_q.key));

	// The output register takes a new word when empty or when its word leaves this cycle.
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_E_LOAD) && out_free;
	assign out_last  = (idx_q == last_idx);

	// RAM address and write selection for each state.
	always_comb begin
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = carry_q;
		case (state_q)
			ST_IDLE: begin
				wr_en   = in_accept && !full;
				wr_addr = count_q[IDX_W-1:0];
				wr_data = '{key: record_key, prn: record_prn, tag: record_tag};
			end
			ST_DISPATCH, ST_B_START, ST_E_START: begin
				rd_addr = '0;
			end
			ST_B_FIRST: begin
				rd_addr = IDX_W'(1);
			end
			ST_B_SCAN: begin
				// The larger of the pair moves on; the smaller settles one slot back.
				rd_addr = idx_q + IDX_W'(1);
				wr_en   = 1'b1;
				wr_addr = idx_q - IDX_W'(1);
				wr_data = carry_gt ? rd_data_q : carry_q;
			end
			ST_B_TAIL: begin
				wr_en   = 1'b1;
				wr_addr = outer_q;
				wr_data = carry_q;
			end
			ST_S_START: begin
				rd_addr = outer_q;
			end
			ST_S_FIRST: begin
				rd_addr = outer_q + IDX_W'(1);
			end
			ST_S_SCAN: begin
				rd_addr = idx_q + IDX_W'(1);
			end
			ST_S_SW1: begin
				wr_en   = 1'b1;
				wr_addr = outer_q;
				wr_data = carry_q;
			end
			ST_S_SW2: begin
				// When the head was already the minimum this rewrites it unchanged.
				wr_en   = 1'b1;
				wr_addr = best_idx_q;
				wr_data = head_q;
			end
			ST_E_LOAD: begin
				rd_addr = out_load ? (idx_q + IDX_W'(1)) : idx_q;
			end
			default: begin
				rd_addr = idx_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rec_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= rec_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METH_BUBBLE;
		end else if (cfg_wr_en) begin
			method_q <= cfg_wr_data;
		end
	end

	// Sequencer: loading, the two sort engines and emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			overflow_q <= 1'b0;
			idx_q      <= '0;
			outer_q    <= '0;
			best_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (last_record) begin
							state_q <= ST_DISPATCH;
						end
					end
				end
				ST_DISPATCH: begin
					// The read of entry zero issued here feeds emission directly when no sort is needed.
					idx_q <= '0;
					if (count_q == CNT_W'(1)) begin
						outer_q <= '0;
						state_q <= ST_E_LOAD;
					end else begin
						case (method_q)
							METH_SELECTION: begin
								outer_q <= '0;
								state_q <= ST_S_START;
							end
							METH_BUBBLE, METH_INSERTION: begin
								outer_q <= last_idx;
								state_q <= ST_B_START;
							end
							default: begin
								outer_q <= '0;
								state_q <= ST_E_LOAD;
							end
						endcase
					end
				end
				ST_B_START: begin
					state_q <= ST_B_FIRST;
				end
				ST_B_FIRST: begin
					idx_q   <= IDX_W'(1);
					state_q <= ST_B_SCAN;
				end
				ST_B_SCAN: begin
					if (idx_q == outer_q) begin
						state_q <= ST_B_TAIL;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_B_TAIL: begin
					if (outer_q == IDX_W'(1)) begin
						state_q <= ST_E_START;
					end else begin
						outer_q <= outer_q - IDX_W'(1);
						state_q <= ST_B_START;
					end
				end
				ST_S_START: begin
					state_q <= ST_S_FIRST;
				end
				ST_S_FIRST: begin
					best_idx_q <= outer_q;
					idx_q      <= outer_q + IDX_W'(1);
					state_q    <= ST_S_SCAN;
				end
				ST_S_SCAN: begin
					if (carry_gt) begin
						best_idx_q <= idx_q;
					end
					if (idx_q == last_idx) begin
						state_q <= ST_S_SW1;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_S_SW1: begin
					state_q <= ST_S_SW2;
				end
				ST_S_SW2: begin
					if (outer_q + IDX_W'(1) == last_idx) begin
						state_q <= ST_E_START;
					end else begin
						outer_q <= outer_q + IDX_W'(1);
						state_q <= ST_S_START;
					end
				end
				ST_E_START: begin
					idx_q   <= '0;
					state_q <= ST_E_LOAD;
				end
				ST_E_LOAD: begin
					if (out_load) begin
						if (out_last) begin
							count_q    <= '0;
							overflow_q <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working records of the sort engines; they need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_B_FIRST: begin
				carry_q <= rd_data_q;
			end
			ST_B_SCAN: begin
				if (!carry_gt) begin
					carry_q <= rd_data_q;
				end
			end
			ST_S_FIRST: begin
				carry_q <= rd_data_q;
				head_q  <= rd_data_q;
			end
			ST_S_SCAN: begin
				// Only a strictly smaller key replaces the best, so the first minimum wins.
				if (carry_gt) begin
					carry_q <= rd_data_q;
				end
			end
			default: begin
				carry_q <= carry_q;
			end
		endcase
	end

	// Output register: a finished word waits here while the next one is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rec_q   <= rd_data_q;
			out_final_q <= out_last;
			out_drop_q  <= overflow_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign sorted_key      = out_rec_q.key;
	assign sorted_prn      = out_rec_q.prn;
	assign sorted_tag      = out_rec_q.tag;
	assign final_result    = out_final_q;
	assign records_dropped = out_drop_q;

	// The record count never passes the RAM depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RECORDS))
		else $error("record count beyond capacity");

	// Sorting only ever writes entries that belong to the current set.
	a_write_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q != ST_IDLE) |-> ({1'b0, wr_addr} < count_q))
		else $error("sort write outside the loaded records");

	// A bubble step never reads the entry it writes in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_B_SCAN && idx_q != outer_q) |-> (wr_addr != rd_addr))
		else $error("read and write of one entry in a bubble step");

	// Loading the final word ends the set and reopens the input.
	a_set_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last) |=> (state_q == ST_IDLE && count_q == '0 && out_valid_q))
		else $error("set not closed after its final word");

endmodule

`default_nettype wire

[tb/record_sort_checker.sv]
`timescale 1ns / 100ps
// Checker for the record sorter: predicts every sorted word and compares it with the output.
module record_sort_checker
	import rsk_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_wr_en,
	input  wire [1:0]               cfg_wr_data,
	input  wire                     in_valid,
	input  wire                     in_stall,
	input  wire signed [KEY_W-1:0]  record_key,
	input  wire signed [PRN_W-1:0]  record_prn,
	input  wire        [TAG_W-1:0]  record_tag,
	input  wire                     last_record,
	input  wire                     out_valid,
	input  wire                     out_stall,
	input  wire signed [KEY_W-1:0]  sorted_key,
	input  wire signed [PRN_W-1:0]  sorted_prn,
	input  wire        [TAG_W-1:0]  sorted_tag,
	input  wire                     final_result,
	input  wire                     records_dropped,
	output int                      error_count,
	output int                      words_due,
	output int                      words_checked,
	output int                      sets_closed,
	output int                      lossy_sets
);

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic signed [PRN_W-1:0] prn;
		logic        [TAG_W-1:0] tag;
		logic                    last_word;
		logic                    dropped;
	} sorted_word_t;

	rec_t         held [MAX_RECORDS];
	int           held_count   = 0;
	logic         overflow     = 1'b0;
	logic [1:0]   method       = METH_BUBBLE;
	sorted_word_t sorted_words_due [$];
	int           errors       = 0;
	int           checked      = 0;
	int           closed       = 0;
	int           lossy        = 0;

	initial begin
		error_count   = 0;
		words_due     = 0;
		words_checked = 0;
		sets_closed   = 0;
		lossy_sets    = 0;
	end

	// Orders the held records by signed key with the method currently selected.
	function automatic void sort_held_records(input int n);
		rec_t tmp;
		int   best;
		int   pos;
		case (method)
		METH_BUBBLE: begin
			for (int p = 0; p + 1 < n; p++)
				for (int j = 0; j + 1 < n - p; j++)
					if ($signed(held[j].key) > $signed(held[j+1].key)) begin
						tmp       = held[j];
						held[j]   = held[j+1];
						held[j+1] = tmp;
					end
		end
		METH_SELECTION: begin
			for (int i = 0; i + 1 < n; i++) begin
				best = i;
				for (int j = i + 1; j < n; j++)
					if ($signed(held[best].key) > $signed(held[j].key))
						best = j;
				if (best != i) begin
					tmp        = held[i];
					held[i]    = held[best];
					held[best] = tmp;
				end
			end
		end
		METH_INSERTION: begin
			for (int i = 1; i < n; i++) begin
				tmp = held[i];
				pos = i;
				while (pos > 0 && $signed(held[pos-1].key) > $signed(tmp.key)) begin
					held[pos] = held[pos-1];
					pos--;
				end
				held[pos] = tmp;
			end
		end
		default: begin
			// Arrival order is kept.
		end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sorted_word_t want;
		if (!arst_n) begin
			held_count = 0;
			overflow   = 1'b0;
			method     = METH_BUBBLE;
			sorted_words_due.delete();
		end else begin
			if (cfg_wr_en)
				method = cfg_wr_data;

			if (out_valid && !out_stall) begin
				if (sorted_words_due.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual key %h prn %h tag %h",
						$time, sorted_key, sorted_prn, sorted_tag);
					errors++;
				end else begin
					want = sorted_words_due.pop_front();
					check_field("sorted_key", want.key, sorted_key);
					check_field("sorted_prn", want.prn, sorted_prn);
					check_field("sorted_tag", KEY_W'(want.tag), KEY_W'(sorted_tag));
					check_field("final_result", KEY_W'(want.last_word), KEY_W'(final_result));
					check_field("records_dropped", KEY_W'(want.dropped),
						KEY_W'(records_dropped));
					checked++;
				end
			end

			if (in_valid && !in_stall) begin
				if (held_count < MAX_RECORDS) begin
					held[held_count] = '{key: record_key, prn: record_prn, tag: record_tag};
					held_count++;
				end else begin
					overflow = 1'b1;
				end
				if (last_record) begin
					sort_held_records(held_count);
					for (int i = 0; i < held_count; i++)
						sorted_words_due.push_back('{key: held[i].key, prn: held[i].prn,
							tag: held[i].tag, last_word: (i + 1 == held_count),
							dropped: overflow});
					closed++;
					if (overflow)
						lossy++;
					held_count = 0;
					overflow   = 1'b0;
				end
			end
		end
		error_count   <= errors;
		words_due     <= sorted_words_due.size();
		words_checked <= checked;
		sets_closed   <= closed;
		lossy_sets    <= lossy;
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top of the record sorter testbench: clock, reset, stimulus and the verdict.
module tb_top;
	import rsk_pkg::*;

	// Kinds of key values a random set is drawn from.
	localparam int KEYS_WIDE      = 0;
	localparam int KEYS_CLUSTERED = 1;
	localparam int KEYS_EXTREME   = 2;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [1:0]              cfg_wr_data;
	logic                    in_valid;
	logic                    in_stall;
	logic signed [KEY_W-1:0] record_key;
	logic signed [PRN_W-1:0] record_prn;
	logic        [TAG_W-1:0] record_tag;
	logic                    last_record;
	logic                    out_valid;
	logic                    out_stall = 1'b1;
	logic signed [KEY_W-1:0] sorted_key;
	logic signed [PRN_W-1:0] sorted_prn;
	logic        [TAG_W-1:0] sorted_tag;
	logic                    final_result;
	logic                    records_dropped;

	int send_idle  = 0;
	int recv_idle  = 0;
	int items_sent = 0;
	int error_count;
	int words_due;
	int words_checked;
	int sets_closed;
	int lossy_sets;

	record_sorter_by_key_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.record_key      (record_key),
		.record_prn      (record_prn),
		.record_tag      (record_tag),
		.last_record     (last_record),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sorted_key      (sorted_key),
		.sorted_prn      (sorted_prn),
		.sorted_tag      (sorted_tag),
		.final_result    (final_result),
		.records_dropped (records_dropped)
	);

	record_sort_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.record_key      (record_key),
		.record_prn      (record_prn),
		.record_tag      (record_tag),
		.last_record     (last_record),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sorted_key      (sorted_key),
		.sorted_prn      (sorted_prn),
		.sorted_tag      (sorted_tag),
		.final_result    (final_result),
		.records_dropped (records_dropped),
		.error_count     (error_count),
		.words_due       (words_due),
		.words_checked   (words_checked),
		.sets_closed     (sets_closed),
		.lossy_sets      (lossy_sets)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The result side stalls at random; recv_idle is the chance in percent per cycle.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Offers one record word and holds it until the block takes it. Before the word the
	// sender may idle, with valid low, as send_idle dictates.
	task automatic send_word(input logic signed [KEY_W-1:0] key,
			input logic signed [PRN_W-1:0] prn, input logic [TAG_W-1:0] tag, input logic last);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		record_key  <= key;
		record_prn  <= prn;
		record_tag  <= tag;
		last_record <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// Stops sending and waits until every predicted word has come out. The extra cycles let
	// the block go back to idle after its last word.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// The mode register may only change while the block is idle, so drain first.
	task automatic set_method(input logic [1:0] code);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= code;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key(input int kind);
		case (kind)
		KEYS_WIDE: return $urandom;
		KEYS_CLUSTERED: return KEY_W'(int'($urandom_range(6)) - 3);
		KEYS_EXTREME: begin
			case ($urandom_range(5))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return 32'sh0000_0000;
			3:       return -32'sd1;
			4:       return 32'sh8000_0001;
			default: return 32'sh7fff_fffe;
			endcase
		end
		default: return $urandom;
		endcase
	endfunction

	// One complete set: n records with random content, the last one flagged.
	task automatic send_set(input int n);
		int kind;
		kind = $urandom_range(2);
		for (int i = 0; i < n; i++)
			send_word(pick_key(kind), $urandom, TAG_W'($urandom), i == n - 1);
	endtask

	initial begin
		int phase_end;
		int set_size;
		int big_size [3];
		int idle_send [3];
		int idle_recv [3];

		// Forced large sets: one that drops only its last record, one that fills the store
		// exactly, and one that drops several records ahead of the last.
		big_size  = '{65, 64, 70};
		idle_send = '{9, 88, 0};
		idle_recv = '{88, 9, 0};

		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= METH_BUBBLE;
		in_valid    <= 1'b0;
		record_key  <= '0;
		record_prn  <= '0;
		record_tag  <= '0;
		last_record <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < 3; p++) begin
			drain_results();
			send_idle <= idle_send[p];
			recv_idle <= idle_recv[p];

			if (p == 0) begin
				// Bubble sort over the key extremes; two equal keys must keep their order.
				set_method(METH_BUBBLE);
				send_word(32'sh7fff_ffff, 32'sh8000_0000, 16'h0000, 1'b0);
				send_word(32'sh8000_0000, 32'sh7fff_ffff, 16'hffff, 1'b0);
				send_word(32'sh0000_0000, -32'sd1,        16'h5555, 1'b0);
				send_word(-32'sd1,        32'sh0000_0000, 16'haaaa, 1'b0);
				send_word(32'sd5,         32'sd1,         16'h0001, 1'b0);
				send_word(32'sd5,         32'sd2,         16'h0002, 1'b1);
				// Selection sort with repeated keys, which it is free to reorder.
				set_method(METH_SELECTION);
				send_word(32'sd3, 32'sd10, 16'h0010, 1'b0);
				send_word(32'sd1, 32'sd11, 16'h0011, 1'b0);
				send_word(32'sd3, 32'sd12, 16'h0012, 1'b0);
				send_word(32'sd1, 32'sd13, 16'h0013, 1'b0);
				send_word(32'sd2, 32'sd14, 16'h0014, 1'b1);
				// Insertion sort, stable, with the most negative key arriving last.
				set_method(METH_INSERTION);
				send_word(32'sd7,         32'sd20, 16'h0020, 1'b0);
				send_word(-32'sd7,        32'sd21, 16'h0021, 1'b0);
				send_word(32'sd7,         32'sd22, 16'h0022, 1'b0);
				send_word(32'sh8000_0000, 32'sd23, 16'h0023, 1'b1);
				// No sorting at all: the words leave in arrival order.
				set_method(METH_NONE);
				send_word(32'sd9, 32'sd30, 16'h0030, 1'b0);
				send_word(32'sd2, 32'sd31, 16'h0031, 1'b0);
				send_word(32'sd5, 32'sd32, 16'h0032, 1'b1);
				// A set of a single record.
				set_method(METH_BUBBLE);
				send_word(-32'sd5, 32'sd40, 16'h0040, 1'b1);
			end

			set_method(2'($urandom_range(3)));
			phase_end = items_sent + 130;
			send_set(big_size[p]);
			while (items_sent < phase_end) begin
				if ($urandom_range(3) == 0)
					set_method(2'($urandom_range(3)));
				if ($urandom_range(99) < 4)
					set_size = $urandom_range(72, 60);
				else
					set_size = $urandom_range(10, 1);
				send_set(set_size);
			end
		end

		drain_results();
		repeat (40) @(posedge clk);

		$display("Sent %0d records in %0d sets, %0d of them over capacity, under all four modes.",
			items_sent, sets_closed, lossy_sets);
		$display("Compared %0d sorted words with both sides idling in turn and then neither.",
			words_checked);
		if (error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Guard against a hung handshake; far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
